>>> rtl/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and constants of the trigram set indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam int TRIGRAM_BITS      = 24;
  localparam int TRIGRAM_SPACE     = 1 << TRIGRAM_BITS;
  localparam int COUNT_BITS        = 25;
  localparam int MAP_WORD_BITS_DEF = 64;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_BITS     = 2;

  localparam logic [COUNT_BITS-1:0] BOUND_RESET = 25'd65536;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 25'h1FFFFFF;

  // Result kinds
  localparam logic KIND_TRIGRAM = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                    result_kind;
    logic [TRIGRAM_BITS-1:0] trigram;
    logic [COUNT_BITS-1:0]   distinct_count;
    logic                    rejected;
    logic                    last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tsi_channels.sv
// ----------------------------------------------------------------------------
// tsi_channels
// Valid/ready channels of the trigram set indexer: file bytes, results and
// the bound register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tsi_result_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [tsi_pkg::TRIGRAM_BITS-1:0] trigram;
  logic [tsi_pkg::COUNT_BITS-1:0]   distinct_count;
  logic                            rejected;
  logic                            last;

  modport source (output valid, output result_kind, output trigram,
                  output distinct_count, output rejected, output last, input ready);
  modport sink   (input valid, input result_kind, input trigram,
                  input distinct_count, input rejected, input last, output ready);
endinterface

interface tsi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsi_pkg::COUNT_BITS-1:0] distinct_bound;

  modport source (output valid, output distinct_bound, input ready);
  modport sink   (input valid, input distinct_bound, output ready);
endinterface

`default_nettype wire

>>> rtl/tsi_word_split.sv
// ----------------------------------------------------------------------------
// tsi_word_split
// Splits a trigram into bitmap word address and bit position. Divide by the
// word width through a registered reciprocal product and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_word_split #(
  parameter int WORD_BITS = tsi_pkg::MAP_WORD_BITS_DEF,
  parameter int ADDR_W    = 18,
  parameter int BIT_W     = 6
) (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire logic [tsi_pkg::TRIGRAM_BITS-1:0] trigram,
  output logic      [ADDR_W-1:0]               word,
  output logic      [BIT_W-1:0]                bit_sel
);

  localparam int TB = tsi_pkg::TRIGRAM_BITS;
  localparam int PW = TB + 32;
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / WORD_BITS);

  logic [TB-1:0] trigram_hold;
  logic [PW-1:0] product;
  logic [TB-1:0] q_est;
  logic [TB-1:0] q_times_w;
  logic [TB-1:0] rem_est;
  logic [TB-1:0] q_fix;
  logic [TB-1:0] rem_fix;

  // Register the reciprocal product; the estimate is low by at most one
  always_ff @(posedge clk) begin
    if (load) begin
      trigram_hold <= trigram;
      product      <= PW'(trigram) * PW'(RECIP);
    end
  end

  always_comb begin
    q_est     = product[31 +: TB];
    q_times_w = TB'(q_est * TB'(WORD_BITS));
    rem_est   = trigram_hold - q_times_w;
    if (rem_est >= TB'(WORD_BITS)) begin
      q_fix   = q_est + TB'(1);
      rem_fix = rem_est - TB'(WORD_BITS);
    end else begin
      q_fix   = q_est;
      rem_fix = rem_est;
    end
  end

  assign word    = q_fix[ADDR_W-1:0];
  assign bit_sel = rem_fix[BIT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/tsi_seen_map.sv
// ----------------------------------------------------------------------------
// tsi_seen_map
// Bitmap of seen trigrams: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_seen_map #(
  parameter int WORD_BITS = tsi_pkg::MAP_WORD_BITS_DEF,
  parameter int DEPTH     = 262144,
  parameter int ADDR_W    = 18
) (
  input  wire logic                 clk,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic      [WORD_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/tsi_result_fifo.sv
// ----------------------------------------------------------------------------
// tsi_result_fifo
// Small result queue between the indexer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_result_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tsi_pkg::result_t push_data,
  output logic                  room_for_two,
  output logic                  out_valid,
  output tsi_pkg::result_t      out_data,
  input  wire logic             out_ready
);

  localparam int PB = tsi_pkg::FIFO_PTR_BITS;

  tsi_pkg::result_t entries [tsi_pkg::FIFO_DEPTH];
  logic [PB-1:0]    wr_ptr;
  logic [PB-1:0]    rd_ptr;
  logic [PB:0]      fill;
  logic             pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = fill != '0;
  assign out_data     = entries[rd_ptr];
  assign room_for_two = fill <= (PB+1)'(tsi_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PB'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PB+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PB+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/trigram_set_indexer_unit.sv
// ----------------------------------------------------------------------------
// trigram_set_indexer_unit
// Distinct-trigram indexer. Feed a file's bytes in order on file_data, with
// end_of_file high on the last byte. Each trigram not yet seen in the file
// comes out on results as a trigram request with the running count; the
// last byte adds a summary request with the count and the rejected flag
// (count above the bound held in bound_cfg). bound_cfg is always ready and
// should be written only while the unit is idle.
// Steps: a byte that forms a trigram is accepted, word split by the
// reciprocal multiplier, then read-modify-written in its bitmap word; the
// first two bytes of a file only fill the window. End of file adds a summary
// step, then a sweep zeroing the bitmap, one word per cycle over DEPTH words
// (262144 at 64-bit words), with no byte taken. Reset starts the same sweep.
// Results wait in a four-entry queue: a stalled receiver holds them there and
// bytes are taken only while the queue has room for two more.
// ----------------------------------------------------------------------------
`default_nettype none

module trigram_set_indexer_unit #(
  parameter int MAP_WORD_BITS = tsi_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tsi_byte_if.sink    file_data,
  tsi_result_if.source results,
  tsi_cfg_if.sink     bound_cfg
);

  localparam int TB     = tsi_pkg::TRIGRAM_BITS;
  localparam int CB     = tsi_pkg::COUNT_BITS;
  localparam int DEPTH  = (tsi_pkg::TRIGRAM_SPACE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIT_W  = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SPLIT   = 5'b00010,
    ST_CHECK   = 5'b00100,
    ST_SUMMARY = 5'b01000,
    ST_CLEAR   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [15:0]            window;
  logic [1:0]             window_fill;
  logic [CB-1:0]          unique_total;
  logic [CB-1:0]          distinct_bound;
  logic [TB-1:0]          trigram_hold;
  logic                   eof_pend;
  logic [ADDR_W-1:0]      word_addr;
  logic [BIT_W-1:0]       bit_pos;
  logic [ADDR_W-1:0]      clr_addr;

  logic                   accept;
  logic [TB-1:0]          trigram_now;
  logic [ADDR_W-1:0]      split_word;
  logic [BIT_W-1:0]       split_bit;
  logic [MAP_WORD_BITS-1:0] map_rd_data;
  logic [MAP_WORD_BITS-1:0] bit_mask;
  logic                   is_new;
  logic                   map_wr_en;
  logic [ADDR_W-1:0]      map_wr_addr;
  logic [MAP_WORD_BITS-1:0] map_wr_data;
  logic [CB-1:0]          count_inc;
  logic                   fifo_push;
  logic                   fifo_room;
  tsi_pkg::result_t       push_data;
  tsi_pkg::result_t       head;

  // Bytes enter only between lookups and with space for a trigram and summary
  assign file_data.ready = (state == ST_IDLE) && fifo_room;
  assign accept          = file_data.valid && file_data.ready;
  assign trigram_now     = {window, file_data.data_byte};

  // Bound register: always ready, to be written only while idle (left to the user)
  assign bound_cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distinct_bound <= tsi_pkg::BOUND_RESET;
    end else if (bound_cfg.valid) begin
      distinct_bound <= bound_cfg.distinct_bound;
    end
  end

  tsi_word_split #(
    .WORD_BITS (MAP_WORD_BITS),
    .ADDR_W    (ADDR_W),
    .BIT_W     (BIT_W)
  ) u_split (
    .clk     (clk),
    .load    (accept),
    .trigram (trigram_now),
    .word    (split_word),
    .bit_sel (split_bit)
  );

  tsi_seen_map #(
    .WORD_BITS (MAP_WORD_BITS),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_map (
    .clk     (clk),
    .rd_addr (split_word),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  // The read issued in SPLIT returns in CHECK; the write-back lands before
  // the next byte can be split, so no forwarding is needed
  assign bit_mask  = MAP_WORD_BITS'(1) << bit_pos;
  assign is_new    = (map_rd_data & bit_mask) == '0;
  assign count_inc = (unique_total < tsi_pkg::COUNT_MAX) ? unique_total + CB'(1)
                                                         : unique_total;

  always_comb begin
    map_wr_en   = 1'b0;
    map_wr_addr = word_addr;
    map_wr_data = map_rd_data | bit_mask;
    if (state == ST_CLEAR) begin
      map_wr_en   = 1'b1;
      map_wr_addr = clr_addr;
      map_wr_data = '0;
    end else if (state == ST_CHECK && is_new) begin
      map_wr_en = 1'b1;
    end
  end

  // Result to queue: a new trigram in CHECK, the summary in SUMMARY
  always_comb begin
    fifo_push                = 1'b0;
    push_data.result_kind    = tsi_pkg::KIND_TRIGRAM;
    push_data.trigram        = trigram_hold;
    push_data.distinct_count = count_inc;
    push_data.rejected       = 1'b0;
    push_data.last           = !eof_pend;
    if (state == ST_CHECK) begin
      fifo_push = is_new;
    end else if (state == ST_SUMMARY) begin
      fifo_push                = 1'b1;
      push_data.result_kind    = tsi_pkg::KIND_SUMMARY;
      push_data.trigram        = '0;
      push_data.distinct_count = unique_total;
      push_data.rejected       = unique_total > distinct_bound;
      push_data.last           = 1'b1;
    end
  end

  tsi_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (fifo_push),
    .push_data    (push_data),
    .room_for_two (fifo_room),
    .out_valid    (results.valid),
    .out_data     (head),
    .out_ready    (results.ready)
  );

  assign results.result_kind    = head.result_kind;
  assign results.trigram        = head.trigram;
  assign results.distinct_count = head.distinct_count;
  assign results.rejected       = head.rejected;
  assign results.last           = head.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (window_fill == 2'd2) begin
            state_next = ST_SPLIT;
          end else if (file_data.end_of_file) begin
            state_next = ST_SUMMARY;
          end
        end
      end
      ST_SPLIT:   state_next = ST_CHECK;
      ST_CHECK:   state_next = eof_pend ? ST_SUMMARY : ST_IDLE;
      ST_SUMMARY: state_next = ST_CLEAR;
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      window       <= '0;
      window_fill  <= '0;
      unique_total <= '0;
      eof_pend     <= 1'b0;
      clr_addr     <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        window   <= {window[7:0], file_data.data_byte};
        eof_pend <= file_data.end_of_file;
        if (window_fill != 2'd2) begin
          window_fill <= window_fill + 2'd1;
        end
      end
      if (state == ST_CHECK && is_new) begin
        unique_total <= count_inc;
      end
      // Drop the file's window and count once the summary is queued
      if (state == ST_SUMMARY) begin
        window       <= '0;
        window_fill  <= '0;
        unique_total <= '0;
        clr_addr     <= '0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Payload registers: hold the trigram and its word split through the lookup
  always_ff @(posedge clk) begin
    if (accept) begin
      trigram_hold <= trigram_now;
    end
    if (state == ST_SPLIT) begin
      word_addr <= split_word;
      bit_pos   <= split_bit;
    end
  end

  // A summary is always the final result of its byte
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.result_kind == tsi_pkg::KIND_SUMMARY |-> results.last)
    else $error("summary result without last");

  // A trigram result always carries a non-zero running count
  a_trigram_count: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.result_kind == tsi_pkg::KIND_TRIGRAM
      |-> results.distinct_count != '0)
    else $error("trigram result with zero count");

  // The file state is empty once the summary has been queued
  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUMMARY |=> window_fill == 2'd0 && unique_total == '0)
    else $error("file state not cleared after summary");

  // The bitmap is checked only on the cycle after its read was issued
  a_check_after_split: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> $past(state) == ST_SPLIT)
    else $error("bitmap check without a preceding read");

endmodule

`default_nettype wire

>>> test/trigram_set_indexer_unit_tb.sv
// ---------------------------------------------------------------------------
// trigram_set_indexer_unit_tb
// Self-checking bench for the trigram set indexer. Streams files of bytes
// through the unit with random gaps on both channels. A behavioural copy of
// the indexer predicts every trigram and summary request. Each delivered
// result is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------

module trigram_set_indexer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsi_pkg::*;

  // Five bitmap sweeps over 262144 words each (reset and four file ends)
  // dominate the run; allow plenty.
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam logic [COUNT_BITS-1:0] BOUND_TOP = 25'd16777216;

  logic clk = 1'b0;
  logic rst;

  tsi_byte_if   byte_ch();
  tsi_result_if result_ch();
  tsi_cfg_if    cfg_ch();

  trigram_set_indexer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .file_data (byte_ch),
    .results   (result_ch),
    .bound_cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural copy of the indexer: window, seen set, count and bound.
  logic [15:0]           window_bytes;
  int unsigned           window_count;
  bit                    gram_seen [int unsigned];
  logic [COUNT_BITS-1:0] distinct_so_far;
  logic [COUNT_BITS-1:0] bound_copy;

  // Results the unit still owes us, oldest first.
  result_t upcoming_results [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_taken    = 0;
  int unsigned results_taken  = 0;
  int unsigned files_closed   = 0;
  int unsigned cycle_count    = 0;

  // When set, neither side inserts gaps: gives stretches at full rate.
  bit steady;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, want 0x%0h (after %0d bytes)",
             what, got, want, bytes_taken);
    mismatch_count++;
  endtask

  // Start a fresh file: empty window, empty seen set, zero count.
  task automatic forget_file;
    window_bytes    = '0;
    window_count    = 0;
    distinct_so_far = '0;
    gram_seen.delete();
  endtask

  // Work out what one accepted byte request produces and queue it.
  task automatic index_byte(input logic [7:0] b, input logic eof);
    logic [23:0] gram;
    result_t     made;
    gram = {window_bytes, b};
    // A trigram exists only once two earlier bytes are held; emit it once.
    if (window_count >= 2 && !gram_seen.exists(int'(gram))) begin
      gram_seen[int'(gram)] = 1'b1;
      if (distinct_so_far != COUNT_MAX) distinct_so_far++;
      made.result_kind    = KIND_TRIGRAM;
      made.trigram        = gram;
      made.distinct_count = distinct_so_far;
      made.rejected       = 1'b0;
      made.last           = !eof;
      upcoming_results    = {upcoming_results, made};
    end
    window_bytes = {window_bytes[7:0], b};
    if (window_count < 2) window_count++;
    // The last byte always adds a summary, which closes the file.
    if (eof) begin
      made.result_kind    = KIND_SUMMARY;
      made.trigram        = '0;
      made.distinct_count = distinct_so_far;
      made.rejected       = (distinct_so_far > bound_copy);
      made.last           = 1'b1;
      upcoming_results    = {upcoming_results, made};
      files_closed++;
      forget_file();
    end
  endtask

  // Compare one delivered result request with the oldest prediction.
  task automatic take_result(input result_t got);
    result_t want;
    results_taken++;
    if (upcoming_results.size() == 0) begin
      report_mismatch("unrequested result, trigram", got.trigram, '0);
    end else begin
      want = upcoming_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.trigram !== want.trigram)
        report_mismatch("trigram", got.trigram, want.trigram);
      if (got.distinct_count !== want.distinct_count)
        report_mismatch("distinct_count", got.distinct_count, want.distinct_count);
      if (got.rejected !== want.rejected)
        report_mismatch("rejected", got.rejected, want.rejected);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
    end
  endtask

  // Result side: sample at the edge, then draw a random stall before taking
  // the next request.
  initial begin : result_sink
    int      hold_left;
    result_t got;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got.result_kind    = result_ch.result_kind;
        got.trigram        = result_ch.trigram;
        got.distinct_count = result_ch.distinct_count;
        got.rejected       = result_ch.rejected;
        got.last           = result_ch.last;
        take_result(got);
        hold_left = steady ? 0 : $urandom_range(0, 3);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      result_ch.ready <= (hold_left == 0);
    end
  end

  // Offer one byte request after a random gap; hold it until taken.
  // Valid is left high so a gapless follower keeps it asserted.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.end_of_file <= eof;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_taken++;
    index_byte(b, eof);
  endtask

  // Drop valid and hold until every predicted result has been delivered.
  task automatic hold_until_drained;
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (upcoming_results.size() != 0);
  endtask

  // Drain, let the pipeline settle, then wait out any bitmap sweep:
  // the unit takes no byte while it clears, so ready marks it idle.
  task automatic await_idle;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_bound(input logic [COUNT_BITS-1:0] value);
    await_idle();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.distinct_bound <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    bound_copy = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Bound of zero; all-zero and all-one trigrams, single-bit extremes,
  // a repeat in mid-file and a repeat on the closing byte (summary only).
  task automatic test_directed_extremes;
    logic [7:0] pattern [17] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
                                 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5};
    steady = 1'b0;
    write_bound('0);
    foreach (pattern[i]) send_byte(pattern[i], i == 16);
  endtask

  // Two-byte file right after a closed one: the window must have been
  // cleared, so only a zero-count summary appears (equal to the bound).
  task automatic test_short_file;
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  // Full-range random bytes under the top bound; calm middle third and one
  // pause until the result queue has drained.
  task automatic test_random_wide;
    write_bound(BOUND_TOP);
    for (int i = 0; i < 330; i++) begin
      steady = (i / 110 == 1);
      if (i == 165) hold_until_drained();
      send_byte(8'($urandom_range(0, 255)), i == 329);
    end
  endtask

  // Small alphabet for many repeats, some noise bytes, and a bound drawn
  // near the likely distinct count so either verdict can come out.
  task automatic test_random_repeats;
    logic [7:0] symbols [8];
    logic [7:0] b;
    foreach (symbols[k]) symbols[k] = 8'($urandom_range(0, 255));
    write_bound(COUNT_BITS'($urandom_range(150, 300)));
    for (int i = 0; i < 304; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      else                           b = symbols[$urandom_range(0, 7)];
      send_byte(b, i == 303);
    end
  endtask

  initial begin : run
    rst                   = 1'b1;
    steady                = 1'b0;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_file   = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.distinct_bound = '0;
    bound_copy            = BOUND_RESET;
    forget_file();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_short_file();
    test_random_wide();
    test_random_repeats();

    // Drain, then let the pipeline show any extra result.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (upcoming_results.size() != 0)
      report_mismatch("results never delivered", upcoming_results.size(), '0);

    $display("Streamed %0d bytes in %0d files, checked %0d results", bytes_taken,
             files_closed, results_taken);
    $display("Bounds tried: zero, top of range and a random mid value");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> trigram_set_indexer_unit.f
rtl/tsi_pkg.sv
rtl/tsi_channels.sv
rtl/tsi_word_split.sv
rtl/tsi_seen_map.sv
rtl/tsi_result_fifo.sv
rtl/trigram_set_indexer_unit.sv
test/trigram_set_indexer_unit_tb.sv
